FILE: sv/rbaf_pkg.sv
// Shared types, constants and helpers of the ring buffer allocator with fences.
package rbaf_pkg;

   // Watch table geometry: two banks of WATCH_DEPTH entries each
   localparam int WATCH_DEPTH = 32;
   localparam int WATCH_AW    = (WATCH_DEPTH > 1) ? $clog2(WATCH_DEPTH) : 1;
   localparam int MEM_DEPTH   = 2 * (1 << WATCH_AW);
   localparam int CNT_W       = 6;
   localparam logic [CNT_W:0] DEPTH_LIMIT = (CNT_W + 1)'(WATCH_DEPTH);

   // Queue between the front and the back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUFFER_SIZE = 2'd0,
      CSR_COHERENT    = 2'd1,
      CSR_BUFFER_KIND = 2'd2,
      CSR_ATOM_SIZE   = 2'd3
   } csr_index_type;

   // Result kinds
   localparam logic [1:0] KIND_WAIT  = 2'd0;
   localparam logic [1:0] KIND_GRANT = 2'd1;
   localparam logic [1:0] KIND_ACK   = 2'd2;

   // Cache actions
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_FLUSH = 2'd1;
   localparam logic [1:0] ACT_INVAL = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_OK           = 2'd0;
   localparam logic [1:0] ERR_OVERSIZE     = 2'd1;
   localparam logic [1:0] ERR_OVER_RESERVE = 2'd2;
   localparam logic [1:0] ERR_TABLE_FULL   = 2'd3;

   // Buffer kinds
   localparam logic [1:0] BUF_UPLOAD   = 2'd0;
   localparam logic [1:0] BUF_DOWNLOAD = 2'd1;
   localparam logic [1:0] BUF_STREAM   = 2'd2;

   // Request item
   typedef struct packed {
      logic        req_type;
      logic [31:0] size;
      logic [16:0] alignment;
      logic [63:0] current_tick;
   } rbaf_req_type;

   // Result item
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [63:0] wait_tick;
      logic [31:0] region_offset;
      logic [31:0] region_size;
      logic        invalidated;
      logic [1:0]  cache_action;
      logic [1:0]  error;
      logic        last;
   } rbaf_rsp_type;

   // Configuration registers
   typedef struct packed {
      logic [31:0] buffer_size;
      logic        coherent;
      logic [1:0]  buffer_kind;
      logic [16:0] atom_size;
   } rbaf_cfg_type;

   // Classified operation passed from the front to the back
   typedef struct packed {
      logic        is_commit;
      logic [32:0] rsize;
      logic [16:0] alignment;
      logic [63:0] tick;
   } rbaf_op_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } rbaf_qstat_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_COMMIT,
      ST_WALK,
      ST_GRANT
   } rbaf_state_type;

   // Round x up with the mask rule; an alignment of zero leaves x as it is.
   function automatic logic [32:0] round_up(input logic [32:0] x, input logic [16:0] a);
      logic [32:0] am1;
      begin
         am1 = {16'd0, a - 17'd1};
         if (a == 17'd0) begin
            return x;
         end
         return (x + am1) & ~am1;
      end
   endfunction

endpackage

FILE: sv/rbaf_front.sv
// Front end: accepts request items and classifies them for the back end.
module rbaf_front (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rbaf_pkg::rbaf_req_type  req_data,
   input  rbaf_pkg::rbaf_cfg_type  cfg,
   input  rbaf_pkg::rbaf_qstat_type qstat,
   output logic                    push,
   output rbaf_pkg::rbaf_op_type   push_op
);
   import rbaf_pkg::*;

   logic atom_round;

   // The request side stalls only while the queue has no room.
   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   // Non-coherent stream buffers round every size up to the atom.
   assign atom_round = !cfg.coherent && (cfg.buffer_kind == BUF_STREAM);

   always_comb begin
      push_op.is_commit = req_data.req_type;
      push_op.rsize     = atom_round ? round_up({1'b0, req_data.size}, cfg.atom_size)
                                     : {1'b0, req_data.size};
      push_op.alignment = req_data.alignment;
      push_op.tick      = req_data.current_tick;
   end

endmodule

FILE: sv/rbaf_queue.sv
// Short queue of classified operations between the front and back ends.
module rbaf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rbaf_pkg::rbaf_op_type    push_op,
   input  logic                     pop,
   output rbaf_pkg::rbaf_op_type    head_op,
   output rbaf_pkg::rbaf_qstat_type qstat
);
   import rbaf_pkg::*;

   rbaf_op_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign qstat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_op     = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: sv/rbaf_back.sv
// Back end: carries out maps and commits, walks the watch table and drives results.
module rbaf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  rbaf_pkg::rbaf_cfg_type   cfg,
   input  rbaf_pkg::rbaf_op_type    head_op,
   input  rbaf_pkg::rbaf_qstat_type qstat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rbaf_pkg::rbaf_rsp_type   rsp_data
);
   import rbaf_pkg::*;

   // Sequencer and working registers
   rbaf_state_type state_ff, state_in;
   rbaf_op_type    op_ff, op_in;
   logic [32:0]    off_ff, off_in;
   logic           oversize_ff, oversize_in;
   logic [31:0]    upper_ff, upper_in;
   logic [31:0]    grant_off_ff, grant_off_in;
   logic           inv_ff, inv_in;

   // Allocator state
   logic [31:0]    write_offset_ff, write_offset_in;
   logic [31:0]    reserved_ff, reserved_in;
   logic           bank_ff, bank_in;
   logic [CNT_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] mark_count_ff, mark_count_in;
   logic           mark_valid_ff, mark_valid_in;
   logic [CNT_W-1:0] wait_index_ff, wait_index_in;
   logic [31:0]    waited_ff, waited_in;

   // Output register
   logic           rsp_valid_ff, rsp_valid_in;
   rbaf_rsp_type   rsp_data_ff, rsp_data_in;

   // Watch memory: bound in the upper word, tick in the lower
   logic [95:0]    watch_mem_ff [MEM_DEPTH];
   logic [95:0]    rd_data_ff;
   logic           mem_we, mem_re;
   logic [WATCH_AW:0] mem_waddr, mem_raddr;
   logic [95:0]    mem_wdata;

   // Combinational helpers
   logic           out_free;
   logic           emit;
   rbaf_rsp_type   emit_data;
   logic [33:0]    map_sum;
   logic           wrap;
   logic [31:0]    new_off;
   logic [31:0]    map_upper;
   logic           walk_armed;
   logic [CNT_W-1:0] walk_index;
   logic [31:0]    walk_waited;
   logic [CNT_W-1:0] walk_count;
   logic           need_walk;
   logic [33:0]    commit_sum;
   logic [31:0]    commit_next;
   logic           table_full;
   logic [CNT_W-1:0] wait_next;
   logic [31:0]    rd_bound;
   logic [63:0]    rd_tick;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_bound = rd_data_ff[95:64];
   assign rd_tick  = rd_data_ff[63:0];

   // Map placement: wrap to zero when the aligned region passes the end.
   assign map_sum   = {1'b0, off_ff} + {1'b0, op_ff.rsize};
   assign wrap      = (map_sum > {2'b00, cfg.buffer_size});
   assign new_off   = wrap ? 32'd0 : off_ff[31:0];
   assign map_upper = wrap ? op_ff.rsize[31:0] : map_sum[31:0];

   // Walk condition as it stands after the placement.
   assign walk_armed  = mark_valid_ff || wrap;
   assign walk_index  = wrap ? '0 : wait_index_ff;
   assign walk_waited = wrap ? 32'd0 : waited_ff;
   assign walk_count  = wrap ? cursor_ff : mark_count_ff;
   assign need_walk   = walk_armed && (map_upper > walk_waited) && (walk_index < walk_count);

   // Commit end offset saturates at the top of the address space.
   assign commit_sum  = {2'b00, write_offset_ff} + {1'b0, op_ff.rsize};
   assign commit_next = (commit_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : commit_sum[31:0];
   assign table_full  = ({1'b0, cursor_ff} >= DEPTH_LIMIT);

   assign wait_next = wait_index_ff + CNT_W'(1);

   // Next state, state updates and result generation.
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      off_in          = off_ff;
      oversize_in     = oversize_ff;
      upper_in        = upper_ff;
      grant_off_in    = grant_off_ff;
      inv_in          = inv_ff;
      write_offset_in = write_offset_ff;
      reserved_in     = reserved_ff;
      bank_in         = bank_ff;
      cursor_in       = cursor_ff;
      mark_count_in   = mark_count_ff;
      mark_valid_in   = mark_valid_ff;
      wait_index_in   = wait_index_ff;
      waited_in       = waited_ff;
      pop             = 1'b0;
      emit            = 1'b0;
      emit_data       = '0;
      mem_we          = 1'b0;
      mem_waddr       = {bank_ff, cursor_ff[WATCH_AW-1:0]};
      mem_wdata       = {commit_next, op_ff.tick};
      mem_re          = 1'b0;
      mem_raddr       = {~bank_ff, wait_next[WATCH_AW-1:0]};

      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop         = 1'b1;
               op_in       = head_op;
               off_in      = round_up({1'b0, write_offset_ff}, head_op.alignment);
               oversize_in = (head_op.rsize > {1'b0, cfg.buffer_size});
               state_in    = head_op.is_commit ? ST_COMMIT : ST_MAP;
            end
         end

         ST_COMMIT: begin
            if (out_free) begin
               emit                    = 1'b1;
               emit_data.result_kind   = KIND_ACK;
               emit_data.region_offset = write_offset_ff;
               emit_data.last          = 1'b1;
               if (op_ff.rsize > {1'b0, reserved_ff}) begin
                  emit_data.error = ERR_OVER_RESERVE;
               end else begin
                  emit_data.region_size  = op_ff.rsize[31:0];
                  emit_data.cache_action = cfg.coherent ? ACT_NONE :
                     ((cfg.buffer_kind == BUF_DOWNLOAD) ? ACT_INVAL : ACT_FLUSH);
                  write_offset_in = commit_next;
                  if (table_full) begin
                     emit_data.error = ERR_TABLE_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     cursor_in = cursor_ff + CNT_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end

         ST_MAP: begin
            if (out_free) begin
               if (oversize_ff) begin
                  emit                    = 1'b1;
                  emit_data.result_kind   = KIND_GRANT;
                  emit_data.region_offset = write_offset_ff;
                  emit_data.error         = ERR_OVERSIZE;
                  emit_data.last          = 1'b1;
                  state_in                = ST_IDLE;
               end else begin
                  reserved_in     = op_ff.rsize[31:0];
                  write_offset_in = new_off;
                  upper_in        = map_upper;
                  grant_off_in    = new_off;
                  inv_in          = wrap;
                  if (wrap) begin
                     mark_count_in = cursor_ff;
                     mark_valid_in = 1'b1;
                     cursor_in     = '0;
                     bank_in       = ~bank_ff;
                     wait_index_in = '0;
                     waited_in     = 32'd0;
                  end
                  if (need_walk) begin
                     // The old bank is the one in use before any swap.
                     mem_re    = 1'b1;
                     mem_raddr = {wrap ? bank_ff : ~bank_ff, walk_index[WATCH_AW-1:0]};
                     state_in  = ST_WALK;
                  end else begin
                     emit                    = 1'b1;
                     emit_data.result_kind   = KIND_GRANT;
                     emit_data.region_offset = new_off;
                     emit_data.region_size   = op_ff.rsize[31:0];
                     emit_data.invalidated   = wrap;
                     emit_data.last          = 1'b1;
                     state_in                = ST_IDLE;
                  end
               end
            end
         end

         ST_WALK: begin
            if (out_free) begin
               emit                  = 1'b1;
               emit_data.result_kind = KIND_WAIT;
               emit_data.wait_tick   = rd_tick;
               waited_in             = rd_bound;
               wait_index_in         = wait_next;
               if ((upper_ff > rd_bound) && (wait_next < mark_count_ff)) begin
                  mem_re = 1'b1;
               end else begin
                  state_in = ST_GRANT;
               end
            end
         end

         ST_GRANT: begin
            if (out_free) begin
               emit                    = 1'b1;
               emit_data.result_kind   = KIND_GRANT;
               emit_data.region_offset = grant_off_ff;
               emit_data.region_size   = op_ff.rsize[31:0];
               emit_data.invalidated   = inv_ff;
               emit_data.last          = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = emit ? emit_data : rsp_data_ff;
   end

   // Control and allocator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         write_offset_ff <= '0;
         reserved_ff     <= '0;
         bank_ff         <= 1'b0;
         cursor_ff       <= '0;
         mark_count_ff   <= '0;
         mark_valid_ff   <= 1'b0;
         wait_index_ff   <= '0;
         waited_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         write_offset_ff <= write_offset_in;
         reserved_ff     <= reserved_in;
         bank_ff         <= bank_in;
         cursor_ff       <= cursor_in;
         mark_count_ff   <= mark_count_in;
         mark_valid_ff   <= mark_valid_in;
         wait_index_ff   <= wait_index_in;
         waited_ff       <= waited_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      off_ff       <= off_in;
      oversize_ff  <= oversize_in;
      upper_ff     <= upper_in;
      grant_off_ff <= grant_off_in;
      inv_ff       <= inv_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Watch memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         watch_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= watch_mem_ff[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/ring_buffer_allocator_with_fences_core.sv
// A commit, or a map that waits on no watch, goes from the queue through the idle state and
// its commit or map state into the result register; a map with wait items also passes walk
// and grant. The sequencer pops an item only after the last result of the one before; wait
// items leave at one per cycle unless the receiver stalls, set by the single registered read
// port of the watch memory. Reset: synchronous; clears queue, sequencer, offsets, counters and
// result valid flag, loads register defaults; the watch memory is left, with no clearing pass.
module ring_buffer_allocator_with_fences_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rbaf_pkg::rbaf_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rbaf_pkg::rbaf_rsp_type            rsp_data,
   input  logic                              csr_we,
   input  logic [rbaf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata
);
   import rbaf_pkg::*;

   rbaf_cfg_type   cfg_ff, cfg_in;
   rbaf_qstat_type qstat;
   rbaf_op_type    push_op, head_op;
   logic           push, pop;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BUFFER_SIZE: cfg_in.buffer_size = csr_wdata;
            CSR_COHERENT:    cfg_in.coherent    = csr_wdata[0];
            CSR_BUFFER_KIND: cfg_in.buffer_kind = csr_wdata[1:0];
            CSR_ATOM_SIZE:   cfg_in.atom_size   = csr_wdata[16:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_size <= 32'd4194304;
         cfg_ff.coherent    <= 1'b1;
         cfg_ff.buffer_kind <= BUF_STREAM;
         cfg_ff.atom_size   <= 17'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbaf_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .qstat     (qstat),
      .push      (push),
      .push_op   (push_op)
   );

   rbaf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .qstat   (qstat)
   );

   rbaf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_op   (head_op),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/rbaf_checker.sv
// Port level checks on the allocator's result channel, bound to the top level.
module rbaf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rbaf_pkg::rbaf_rsp_type rsp_data
);
   import rbaf_pkg::*;

   // A result held back by the receiver keeps its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Wait items are never final and carry no range or error.
   a_wait_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_kind == KIND_WAIT) |->
         !rsp_data.last && (rsp_data.region_size == 32'd0) && (rsp_data.error == ERR_OK))
      else $error("malformed wait item");

   // Only commit acknowledges carry a cache action.
   a_action_on_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.cache_action != ACT_NONE) |->
         (rsp_data.result_kind == KIND_ACK) && (rsp_data.error != ERR_OVER_RESERVE))
      else $error("cache action on wrong item");

   // A rejected map grants nothing and ends its request.
   a_oversize_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.result_kind == KIND_GRANT) && (rsp_data.error == ERR_OVERSIZE) |->
         rsp_data.last && (rsp_data.region_size == 32'd0) && !rsp_data.invalidated)
      else $error("oversize grant carries a region");

endmodule

bind ring_buffer_allocator_with_fences_core rbaf_checker u_rbaf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
